@@ rtl/cmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cmpc_pkg
// Shared types and constants of the cascade motor position controller:
// the transfer payloads, the register map and the fixed-point sizes.
// ----------------------------------------------------------------------------
package cmpc_pkg;

    // Fixed-point sizes.
    localparam int DUTY_BITS = 10;
    localparam int VEL_W     = 32;
    localparam int INT_W     = 48;
    localparam int POS_W     = 48;
    localparam int MUL_A_W   = 50;
    localparam int MUL_B_W   = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
    localparam int DIV_W     = 32;
    localparam int CFG_ADDR_W = 5;

    // Full-on PWM compare value.
    localparam logic [10:0] DUTY_FULL = 11'(1 << DUTY_BITS);

    // Velocity saturation bounds.
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    // Register reset values.
    localparam logic [31:0] RST_VELOCITY_SCALE = 32'd72000000;
    localparam logic [15:0] RST_POSITION_SCALE = 16'd72;
    localparam logic [15:0] RST_FILTER_COEF    = 16'd16384;
    localparam logic [15:0] RST_KP_INNER       = 16'd3912;
    localparam logic [15:0] RST_KI_INNER       = 16'd391;
    localparam logic [15:0] RST_KP_OUTER       = 16'd412;
    localparam logic [11:0] RST_VOLT_LIMIT     = 12'd768;
    localparam logic [19:0] RST_DUTY_PER_VOLT  = 20'd52429;

    // Register map, word index.
    typedef enum logic [2:0] {
        REG_VELOCITY_SCALE = 3'd0,
        REG_POSITION_SCALE = 3'd1,
        REG_FILTER_COEF    = 3'd2,
        REG_KP_INNER       = 3'd3,
        REG_KI_INNER       = 3'd4,
        REG_KP_OUTER       = 3'd5,
        REG_VOLT_LIMIT     = 3'd6,
        REG_DUTY_PER_VOLT  = 3'd7
    } reg_index_t;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_FILTER = 2'd1,
        KIND_INNER  = 2'd2,
        KIND_OUTER  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        edge_period_us;
        logic               channel_b_level;
        logic signed [47:0] target_position_q8;
    } in_item_t;

    typedef struct packed {
        logic [10:0]        duty_a;
        logic [10:0]        duty_b;
        logic signed [47:0] position_q8;
        logic signed [31:0] filtered_velocity_q8;
        logic signed [31:0] velocity_target_q8;
    } out_item_t;

endpackage

@@ rtl/cmpc_divider.sv @@
// ----------------------------------------------------------------------------
// cmpc_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmpc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cmpc_pkg::DIV_W-1:0]  dividend,
    input  logic [cmpc_pkg::DIV_W-1:0]  divisor,
    output logic [cmpc_pkg::DIV_W-1:0]  quotient,
    output logic                        done
);

    localparam int CNT_W = $clog2(cmpc_pkg::DIV_W);

    logic [cmpc_pkg::DIV_W-1:0] quo_reg;
    logic [cmpc_pkg::DIV_W-1:0] div_reg;
    logic [cmpc_pkg::DIV_W:0]   rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [cmpc_pkg::DIV_W:0]   shifted;
    logic [cmpc_pkg::DIV_W:0]   trial;

    // Shift in the next dividend bit and try the subtraction.
    assign shifted = {rem_reg[cmpc_pkg::DIV_W-1:0], quo_reg[cmpc_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(cmpc_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the iteration.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[cmpc_pkg::DIV_W])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[cmpc_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[cmpc_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/cmpc_multiplier.sv @@
// ----------------------------------------------------------------------------
// cmpc_multiplier
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cmpc_multiplier (
    input  logic                                clk,
    input  logic signed [cmpc_pkg::MUL_A_W-1:0] op_a,
    input  logic        [cmpc_pkg::MUL_B_W-1:0] op_b,
    output logic signed [cmpc_pkg::PROD_W-1:0]  product
);

    logic signed [cmpc_pkg::PROD_W-1:0] product_reg;

    // One product per cycle, ready the cycle after the operands.
    always_ff @(posedge clk)
    begin
        product_reg <= op_a * $signed({1'b0, op_b});
    end

    assign product = product_reg;

endmodule

@@ rtl/cascade_motor_position_controller_unit.sv @@
// Sequencing: an encoder edge runs through the bit-serial divider first; filter,
// inner and outer ticks skip it, and every item is sequenced through one shared
// multiplier.
// Throughput: one item at a time; the next item is taken once the result is loaded.
// Reset: rst_n clears all loop state and loads the register defaults; both duty
// registers reset to full on.
// ----------------------------------------------------------------------------
// cascade_motor_position_controller_unit
// Cascade position/velocity controller for a DC motor: encoder velocity with
// median-of-three, low-pass filter, PI velocity loop with PWM duty output and
// a proportional position loop, with all products sequenced over one multiplier.
// ----------------------------------------------------------------------------
module cascade_motor_position_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cmpc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cmpc_pkg::out_item_t                 out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmpc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_EDGE, S_POS, S_POS_WR, S_LP_MUL, S_LP_ADD, S_INT,
        S_KI, S_KP, S_U, S_DMUL, S_DUTY, S_OUT_MUL, S_OUT_FIN, S_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [31:0] velocity_scale_reg;
    logic [15:0] position_scale_reg;
    logic [15:0] filter_coef_reg;
    logic [15:0] kp_inner_reg;
    logic [15:0] ki_inner_reg;
    logic [15:0] kp_outer_reg;
    logic [11:0] volt_limit_reg;
    logic [19:0] duty_per_volt_reg;

    // Loop state.
    cmpc_pkg::in_item_t                         item_reg;
    logic [31:0]                                pulse_reg;
    logic signed [cmpc_pkg::VEL_W-1:0]          last_vel_reg;
    logic signed [cmpc_pkg::VEL_W-1:0]          older_vel_reg;
    logic signed [cmpc_pkg::VEL_W-1:0]          median_reg;
    logic signed [cmpc_pkg::VEL_W-1:0]          lowpass_reg;
    logic signed [cmpc_pkg::INT_W-1:0]          integral_reg;
    logic signed [cmpc_pkg::VEL_W-1:0]          vref_reg;
    logic [10:0]                                duty_a_reg;
    logic [10:0]                                duty_b_reg;
    logic signed [cmpc_pkg::POS_W-1:0]          position_reg;
    logic signed [cmpc_pkg::PROD_W-1:0]         acc_reg;
    logic [11:0]                                u_mag_reg;
    logic                                       u_neg_reg;
    logic                                       out_valid_reg;
    cmpc_pkg::out_item_t                        out_reg;

    logic                                       accept;
    logic                                       cfg_write;
    logic                                       out_free;
    logic                                       div_start;
    logic                                       div_done;
    logic [31:0]                                quotient;
    logic signed [cmpc_pkg::MUL_A_W-1:0]        op_a;
    logic [cmpc_pkg::MUL_B_W-1:0]               op_b;
    logic signed [cmpc_pkg::PROD_W-1:0]         product;

    logic [31:0]                                q_sat;
    logic signed [31:0]                         vel_new;
    logic signed [31:0]                         median_next;
    logic signed [31:0]                         lo_pair;
    logic signed [31:0]                         hi_pair;
    logic signed [31:0]                         mid_pair;
    logic signed [32:0]                         lp_diff;
    logic signed [cmpc_pkg::PROD_W-1:0]         lp_step;
    logic signed [32:0]                         vel_err;
    logic signed [48:0]                         int_sum;
    logic signed [cmpc_pkg::INT_W-1:0]          integral_next;
    logic signed [cmpc_pkg::PROD_W-1:0]         u_sum;
    logic signed [cmpc_pkg::PROD_W-1:0]         u_sh;
    logic signed [cmpc_pkg::PROD_W-1:0]         u_abs;
    logic signed [cmpc_pkg::PROD_W-1:0]         lim_s;
    logic [11:0]                                u_mag_next;
    logic                                       u_neg_next;
    logic [32:0]                                red_sum;
    logic [16:0]                                reduction;
    logic [10:0]                                duty_cut;
    logic signed [48:0]                         pos_err;
    logic signed [cmpc_pkg::PROD_W-1:0]         ref_sh;
    logic signed [31:0]                         vref_next;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = (state_reg == S_IDLE) && accept
                       && (in_data.kind == cmpc_pkg::KIND_EDGE);

    // Shared units.
    cmpc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (velocity_scale_reg),
        .divisor  (in_data.edge_period_us),
        .quotient (quotient),
        .done     (div_done)
    );

    cmpc_multiplier u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    // Velocity from the quotient, saturated, with the direction applied.
    always_comb
    begin
        if ((item_reg.edge_period_us == 32'd0) || (quotient > 32'(cmpc_pkg::VEL_MAX)))
        begin
            q_sat = 32'(cmpc_pkg::VEL_MAX);
        end
        else
        begin
            q_sat = quotient;
        end
        vel_new  = item_reg.channel_b_level ? $signed(q_sat) : -$signed(q_sat);
        lo_pair  = (vel_new < last_vel_reg) ? vel_new : last_vel_reg;
        hi_pair  = (vel_new > last_vel_reg) ? vel_new : last_vel_reg;
        mid_pair = (hi_pair < older_vel_reg) ? hi_pair : older_vel_reg;
        median_next = (lo_pair > mid_pair) ? lo_pair : mid_pair;
    end

    // Error terms and the integral with saturation.
    always_comb
    begin
        lp_diff = {median_reg[31], median_reg} - {lowpass_reg[31], lowpass_reg};
        lp_step = product >>> 16;
        vel_err = {vref_reg[31], vref_reg} - {lowpass_reg[31], lowpass_reg};
        int_sum = {integral_reg[47], integral_reg} + {{16{vel_err[32]}}, vel_err};
        if (int_sum[48] != int_sum[47])
        begin
            integral_next = int_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            integral_next = int_sum[47:0];
        end
        pos_err = {item_reg.target_position_q8[47], item_reg.target_position_q8}
                  - {position_reg[47], position_reg};
    end

    // Drive voltage with the magnitude limit.
    always_comb
    begin
        u_sum = acc_reg + product;
        u_sh  = u_sum >>> 16;
        u_abs = (u_sh < 0) ? -u_sh : u_sh;
        lim_s = $signed({{(cmpc_pkg::PROD_W-12){1'b0}}, volt_limit_reg});
        if (u_sh > lim_s)
        begin
            u_mag_next = volt_limit_reg;
            u_neg_next = 1'b0;
        end
        else if (u_sh < -lim_s)
        begin
            u_mag_next = volt_limit_reg;
            u_neg_next = 1'b1;
        end
        else
        begin
            u_mag_next = u_abs[11:0];
            u_neg_next = (u_sh < 0);
        end
    end

    // Duty reduction rounded up, and the velocity reference clamp.
    always_comb
    begin
        red_sum   = {1'b0, product[31:0]} + 33'd65535;
        reduction = red_sum[32:16];
        if (reduction >= 17'(cmpc_pkg::DUTY_FULL))
        begin
            duty_cut = 11'd0;
        end
        else
        begin
            duty_cut = cmpc_pkg::DUTY_FULL - reduction[10:0];
        end
        ref_sh = product >>> 8;
        if (ref_sh > cmpc_pkg::VEL_MAX)
        begin
            vref_next = cmpc_pkg::VEL_MAX;
        end
        else if (ref_sh < cmpc_pkg::VEL_MIN)
        begin
            vref_next = cmpc_pkg::VEL_MIN;
        end
        else
        begin
            vref_next = ref_sh[31:0];
        end
    end

    // Multiplier operand selection by sequencer step.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_POS:
            begin
                op_a = {{18{pulse_reg[31]}}, pulse_reg};
                op_b = {4'd0, position_scale_reg};
            end
            S_LP_MUL:
            begin
                op_a = {{17{lp_diff[32]}}, lp_diff};
                op_b = {4'd0, filter_coef_reg};
            end
            S_KI:
            begin
                op_a = {{2{integral_reg[47]}}, integral_reg};
                op_b = {4'd0, ki_inner_reg};
            end
            S_KP:
            begin
                op_a = {{17{vel_err[32]}}, vel_err};
                op_b = {4'd0, kp_inner_reg};
            end
            S_DMUL:
            begin
                op_a = {38'd0, u_mag_reg};
                op_b = duty_per_volt_reg;
            end
            S_OUT_MUL:
            begin
                op_a = {pos_err[48], pos_err};
                op_b = {4'd0, kp_outer_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Register readback.
    always_comb
    begin
        unique case (cmpc_pkg::reg_index_t'(paddr[4:2]))
            cmpc_pkg::REG_VELOCITY_SCALE: prdata = velocity_scale_reg;
            cmpc_pkg::REG_POSITION_SCALE: prdata = {16'd0, position_scale_reg};
            cmpc_pkg::REG_FILTER_COEF:    prdata = {16'd0, filter_coef_reg};
            cmpc_pkg::REG_KP_INNER:       prdata = {16'd0, kp_inner_reg};
            cmpc_pkg::REG_KI_INNER:       prdata = {16'd0, ki_inner_reg};
            cmpc_pkg::REG_KP_OUTER:       prdata = {16'd0, kp_outer_reg};
            cmpc_pkg::REG_VOLT_LIMIT:     prdata = {20'd0, volt_limit_reg};
            cmpc_pkg::REG_DUTY_PER_VOLT:  prdata = {12'd0, duty_per_volt_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_scale_reg <= cmpc_pkg::RST_VELOCITY_SCALE;
            position_scale_reg <= cmpc_pkg::RST_POSITION_SCALE;
            filter_coef_reg    <= cmpc_pkg::RST_FILTER_COEF;
            kp_inner_reg       <= cmpc_pkg::RST_KP_INNER;
            ki_inner_reg       <= cmpc_pkg::RST_KI_INNER;
            kp_outer_reg       <= cmpc_pkg::RST_KP_OUTER;
            volt_limit_reg     <= cmpc_pkg::RST_VOLT_LIMIT;
            duty_per_volt_reg  <= cmpc_pkg::RST_DUTY_PER_VOLT;
        end
        else if (cfg_write)
        begin
            unique case (cmpc_pkg::reg_index_t'(paddr[4:2]))
                cmpc_pkg::REG_VELOCITY_SCALE: velocity_scale_reg <= pwdata;
                cmpc_pkg::REG_POSITION_SCALE: position_scale_reg <= pwdata[15:0];
                cmpc_pkg::REG_FILTER_COEF:    filter_coef_reg    <= pwdata[15:0];
                cmpc_pkg::REG_KP_INNER:       kp_inner_reg       <= pwdata[15:0];
                cmpc_pkg::REG_KI_INNER:       ki_inner_reg       <= pwdata[15:0];
                cmpc_pkg::REG_KP_OUTER:       kp_outer_reg       <= pwdata[15:0];
                cmpc_pkg::REG_VOLT_LIMIT:     volt_limit_reg     <= pwdata[11:0];
                cmpc_pkg::REG_DUTY_PER_VOLT:  duty_per_volt_reg  <= pwdata[19:0];
                default:                      velocity_scale_reg <= velocity_scale_reg;
            endcase
        end
    end

    // Sequencer with the loop state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            pulse_reg     <= '0;
            last_vel_reg  <= '0;
            older_vel_reg <= '0;
            median_reg    <= '0;
            lowpass_reg   <= '0;
            integral_reg  <= '0;
            vref_reg      <= '0;
            duty_a_reg    <= cmpc_pkg::DUTY_FULL;
            duty_b_reg    <= cmpc_pkg::DUTY_FULL;
            position_reg  <= '0;
            acc_reg       <= '0;
            u_mag_reg     <= '0;
            u_neg_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // A delivered result frees the output register unless a new one loads now.
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= in_data;
                        state_reg <= (in_data.kind == cmpc_pkg::KIND_EDGE) ? S_DIV : S_POS;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    pulse_reg     <= item_reg.channel_b_level ? pulse_reg + 32'd1
                                                              : pulse_reg - 32'd1;
                    older_vel_reg <= last_vel_reg;
                    last_vel_reg  <= vel_new;
                    median_reg    <= median_next;
                    state_reg     <= S_POS;
                end
                S_POS:
                begin
                    state_reg <= S_POS_WR;
                end
                S_POS_WR:
                begin
                    position_reg <= product[cmpc_pkg::POS_W-1:0];
                    unique case (cmpc_pkg::kind_t'(item_reg.kind))
                        cmpc_pkg::KIND_EDGE:   state_reg <= S_FIN;
                        cmpc_pkg::KIND_FILTER: state_reg <= S_LP_MUL;
                        cmpc_pkg::KIND_INNER:  state_reg <= S_INT;
                        cmpc_pkg::KIND_OUTER:  state_reg <= S_OUT_MUL;
                        default:               state_reg <= S_FIN;
                    endcase
                end
                S_LP_MUL:
                begin
                    state_reg <= S_LP_ADD;
                end
                S_LP_ADD:
                begin
                    lowpass_reg <= lowpass_reg + lp_step[31:0];
                    state_reg   <= S_FIN;
                end
                S_INT:
                begin
                    integral_reg <= integral_next;
                    state_reg    <= S_KI;
                end
                S_KI:
                begin
                    state_reg <= S_KP;
                end
                S_KP:
                begin
                    acc_reg   <= product;
                    state_reg <= S_U;
                end
                S_U:
                begin
                    u_mag_reg <= u_mag_next;
                    u_neg_reg <= u_neg_next;
                    state_reg <= S_DMUL;
                end
                S_DMUL:
                begin
                    state_reg <= S_DUTY;
                end
                S_DUTY:
                begin
                    if (u_neg_reg)
                    begin
                        duty_a_reg <= duty_cut;
                        duty_b_reg <= cmpc_pkg::DUTY_FULL;
                    end
                    else
                    begin
                        duty_a_reg <= cmpc_pkg::DUTY_FULL;
                        duty_b_reg <= duty_cut;
                    end
                    state_reg <= S_FIN;
                end
                S_OUT_MUL:
                begin
                    state_reg <= S_OUT_FIN;
                end
                S_OUT_FIN:
                begin
                    vref_reg  <= vref_next;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg.duty_a               <= duty_a_reg;
                        out_reg.duty_b               <= duty_b_reg;
                        out_reg.position_q8          <= position_reg;
                        out_reg.filtered_velocity_q8 <= lowpass_reg;
                        out_reg.velocity_target_q8   <= vref_reg;
                        out_valid_reg                <= 1'b1;
                        state_reg                    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // One bridge input is always full on in a delivered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.duty_a == cmpc_pkg::DUTY_FULL
                       || out_data.duty_b == cmpc_pkg::DUTY_FULL))
        else $error("neither duty is full on");

    // A transfer in blocks the next one until the sequencer is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while item in flight");

    // A result only appears from the final sequencer step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside final step");
`endif

endmodule
